### hw/rtl/tcce_pkg.sv
// shared types, constants and font tables for the text console cell engine
`timescale 1ns / 1ps
package tcce_pkg;

  localparam int CELL_HEIGHT_DEF = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK = 2'd2;

  localparam logic [1:0] FUNC_CHAR = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] KIND_ROW = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // segment ops run by the back end
  localparam logic [2:0] OP_ERASE = 3'd0;
  localparam logic [2:0] OP_PAINT = 3'd1;
  localparam logic [2:0] OP_GLYPH = 3'd2;
  localparam logic [2:0] OP_SCROLL = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [63:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] cell_col;
    logic [8:0] cell_row;
    logic [3:0] pixel_row;
    logic [7:0] pixel_mask;
    logic       mask_color;
    logic       last;
  } out_item_t;

  // one queued segment: a run of commands at one cell
  typedef struct packed {
    logic [2:0] op;
    logic [9:0] col;
    logic [8:0] row;
    logic [5:0] glyph;
    logic       last;
  } seg_t;

  // room for five segments; an input item uses up to four
  typedef struct packed {
    logic [2:0] count;
    seg_t [4:0] segs;
  } plan_t;

  function automatic logic [5:0] font_index(input logic [7:0] ch_in);
    logic [7:0] ch;
    ch = ch_in;
    if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'd32;
    if (ch >= 8'h41 && ch <= 8'h5A) return 6'(ch - 8'h41 + 8'd1);
    if (ch >= 8'h30 && ch <= 8'h39) return 6'(ch - 8'h30 + 8'd27);
    case (ch)
      8'h2F, 8'h5C: return 6'd37;
      8'h23: return 6'd38;
      8'h2E: return 6'd39;
      8'h2D: return 6'd40;
      8'h3A: return 6'd41;
      8'h3D: return 6'd42;
      8'h5F: return 6'd43;
      8'h2B: return 6'd44;
      8'h3C: return 6'd45;
      8'h3E: return 6'd46;
      8'h28: return 6'd47;
      8'h29: return 6'd48;
      8'h21: return 6'd49;
      8'h3F: return 6'd50;
      8'h2C: return 6'd51;
      8'h3B: return 6'd52;
      8'h22: return 6'd53;
      8'h27: return 6'd54;
      8'h2A: return 6'd55;
      8'h40: return 6'd56;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [34:0] font_glyph(input logic [5:0] gi);
    case (gi)
      6'd1:  return {5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      6'd2:  return {5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30};
      6'd3:  return {5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14};
      6'd4:  return {5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30};
      6'd5:  return {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31};
      6'd6:  return {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16};
      6'd7:  return {5'd14,5'd17,5'd16,5'd23,5'd17,5'd17,5'd14};
      6'd8:  return {5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      6'd9:  return {5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd31};
      6'd10: return {5'd1,5'd1,5'd1,5'd1,5'd17,5'd17,5'd14};
      6'd11: return {5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17};
      6'd12: return {5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31};
      6'd13: return {5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17};
      6'd14: return {5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17};
      6'd15: return {5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      6'd16: return {5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16};
      6'd17: return {5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13};
      6'd18: return {5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17};
      6'd19: return {5'd15,5'd16,5'd16,5'd14,5'd1,5'd1,5'd30};
      6'd20: return {5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4};
      6'd21: return {5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      6'd22: return {5'd17,5'd17,5'd17,5'd17,5'd17,5'd10,5'd4};
      6'd23: return {5'd17,5'd17,5'd17,5'd21,5'd21,5'd21,5'd10};
      6'd24: return {5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17};
      6'd25: return {5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4};
      6'd26: return {5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31};
      6'd27: return {5'd14,5'd17,5'd19,5'd21,5'd25,5'd17,5'd14};
      6'd28: return {5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14};
      6'd29: return {5'd14,5'd17,5'd1,5'd2,5'd4,5'd8,5'd31};
      6'd30: return {5'd30,5'd1,5'd1,5'd14,5'd1,5'd1,5'd30};
      6'd31: return {5'd2,5'd6,5'd10,5'd18,5'd31,5'd2,5'd2};
      6'd32: return {5'd31,5'd16,5'd30,5'd1,5'd1,5'd17,5'd14};
      6'd33: return {5'd6,5'd8,5'd16,5'd30,5'd17,5'd17,5'd14};
      6'd34: return {5'd31,5'd1,5'd2,5'd4,5'd8,5'd8,5'd8};
      6'd35: return {5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14};
      6'd36: return {5'd14,5'd17,5'd17,5'd15,5'd1,5'd2,5'd12};
      6'd37: return {5'd1,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16};
      6'd38: return {5'd10,5'd10,5'd31,5'd10,5'd31,5'd10,5'd10};
      6'd39: return {5'd0,5'd0,5'd0,5'd0,5'd0,5'd12,5'd12};
      6'd40: return {5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0};
      6'd41: return {5'd0,5'd12,5'd12,5'd0,5'd12,5'd12,5'd0};
      6'd42: return {5'd0,5'd0,5'd31,5'd0,5'd31,5'd0,5'd0};
      6'd43: return {5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd31};
      6'd44: return {5'd0,5'd4,5'd4,5'd31,5'd4,5'd4,5'd0};
      6'd45: return {5'd2,5'd4,5'd8,5'd16,5'd8,5'd4,5'd2};
      6'd46: return {5'd8,5'd4,5'd2,5'd1,5'd2,5'd4,5'd8};
      6'd47: return {5'd4,5'd8,5'd16,5'd16,5'd16,5'd8,5'd4};
      6'd48: return {5'd8,5'd4,5'd2,5'd2,5'd2,5'd4,5'd8};
      6'd49: return {5'd4,5'd4,5'd4,5'd4,5'd0,5'd0,5'd4};
      6'd50: return {5'd14,5'd17,5'd1,5'd2,5'd4,5'd0,5'd4};
      6'd51: return {5'd0,5'd0,5'd0,5'd0,5'd4,5'd4,5'd8};
      6'd52: return {5'd0,5'd12,5'd12,5'd0,5'd12,5'd4,5'd8};
      6'd53: return {5'd10,5'd10,5'd10,5'd0,5'd0,5'd0,5'd0};
      6'd54: return {5'd4,5'd4,5'd4,5'd0,5'd0,5'd0,5'd0};
      6'd55: return {5'd0,5'd10,5'd4,5'd31,5'd4,5'd10,5'd0};
      6'd56: return {5'd14,5'd17,5'd23,5'd21,5'd23,5'd16,5'd14};
      default: return 35'd0;
    endcase
  endfunction

endpackage

### hw/rtl/tcce_front.sv
// front end: classifies each item, updates cursor state and plans segments
`timescale 1ns / 1ps
module tcce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcce_pkg::in_item_t in_item,
  output logic              plan_valid,
  input  logic              plan_ready,
  output tcce_pkg::plan_t   plan
);
  import tcce_pkg::*;

  logic [10:0] columns;
  logic [9:0]  rows;
  logic [15:0] blink_period;
  logic [9:0]  cursor_column;
  logic [8:0]  cursor_line;
  logic        cursor_visible;
  logic [63:0] last_toggle_time;
  logic [63:0] tick_diff;
  logic        tick_due;

  logic [10:0] eff_cols;
  logic [9:0]  eff_rows;
  logic [9:0]  col_next;
  logic [8:0]  line_next;
  logic        vis_next;
  logic        toggle;
  plan_t       p;
  logic [2:0]  n;
  logic [7:0]  ch;
  logic [10:0] col_inc;
  logic [9:0]  line_inc;

  assign in_ready = !plan_valid || plan_ready;
  assign tick_diff = in_item.tick_count - last_toggle_time;
  assign tick_due = tick_diff >= {48'd0, blink_period};

  always_comb begin
    if (columns < 11'd2) eff_cols = 11'd2;
    else if (columns > 11'd1024) eff_cols = 11'd1024;
    else eff_cols = columns;
    if (rows < 10'd2) eff_rows = 10'd2;
    else if (rows > 10'd512) eff_rows = 10'd512;
    else eff_rows = rows;
  end

  function automatic seg_t mk(input logic [2:0] op, input logic [9:0] c,
                              input logic [8:0] r, input logic [5:0] g);
    seg_t s;
    s.op = op;
    s.col = c;
    s.row = r;
    s.glyph = g;
    s.last = 1'b0;
    return s;
  endfunction

  always_comb begin
    p = '0;
    n = 3'd0;
    col_next = cursor_column;
    line_next = cursor_line;
    vis_next = cursor_visible;
    toggle = 1'b0;
    ch = (in_item.char_code == 8'd9) ? 8'h20 : in_item.char_code;
    col_inc = {1'b0, cursor_column} + 11'd1;
    line_inc = {1'b0, cursor_line} + 10'd1;
    case (in_item.func)
      FUNC_CHAR: begin
        if (cursor_visible) begin
          p.segs[n] = mk(OP_ERASE, cursor_column, cursor_line, 6'd0);
          n = n + 3'd1;
        end
        vis_next = 1'b1;
        if (ch == 8'd13) begin
          col_next = '0;
        end else if (ch == 8'd10 || ch != 8'd8) begin
          if (ch != 8'd10) begin
            p.segs[n] = mk(OP_GLYPH, cursor_column, cursor_line, font_index(ch));
            n = n + 3'd1;
          end
          if (ch == 8'd10 || col_inc >= eff_cols) begin
            col_next = '0;
            if (line_inc >= eff_rows) begin
              p.segs[n] = mk(OP_SCROLL, '0, '0, 6'd0);
              n = n + 3'd1;
              line_next = 9'(eff_rows - 10'd1);
            end else begin
              line_next = line_inc[8:0];
            end
          end else begin
            col_next = col_inc[9:0];
          end
        end else if (cursor_column != '0) begin
          col_next = cursor_column - 10'd1;
          p.segs[n] = mk(OP_ERASE, col_next, cursor_line, 6'd0);
          n = n + 3'd1;
        end
        p.segs[n] = mk(OP_PAINT, col_next, line_next, 6'd0);
        n = n + 3'd1;
      end
      FUNC_TICK: begin
        if (tick_due) begin
          toggle = 1'b1;
          vis_next = !cursor_visible;
          p.segs[n] = mk(cursor_visible ? OP_ERASE : OP_PAINT, cursor_column,
                         cursor_line, 6'd0);
          n = n + 3'd1;
        end
      end
      FUNC_CLEAR: begin
        if (cursor_visible) begin
          p.segs[n] = mk(OP_ERASE, cursor_column, cursor_line, 6'd0);
          n = n + 3'd1;
        end
        p.segs[n] = mk(OP_CLEAR, '0, '0, 6'd0);
        n = n + 3'd1;
        col_next = '0;
        line_next = '0;
        vis_next = 1'b1;
        p.segs[n] = mk(OP_PAINT, '0, '0, 6'd0);
        n = n + 3'd1;
      end
      default: ;
    endcase
    if (n != 3'd0) p.segs[n - 3'd1].last = 1'b1;
    p.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= 11'd80;
      rows <= 10'd25;
      blink_period <= 16'd50;
      cursor_column <= '0;
      cursor_line <= '0;
      cursor_visible <= 1'b0;
      last_toggle_time <= '0;
      plan_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS: columns <= cfg_data[10:0];
          REG_ROWS: rows <= cfg_data[9:0];
          REG_BLINK: blink_period <= cfg_data;
          default: ;
        endcase
      end
      if (plan_ready) plan_valid <= 1'b0;
      if (in_valid && in_ready) begin
        cursor_column <= col_next;
        cursor_line <= line_next;
        cursor_visible <= vis_next;
        if (toggle) last_toggle_time <= in_item.tick_count;
        // items with no command produce no plan
        if (n != 3'd0) begin
          plan_valid <= 1'b1;
          plan <= p;
        end
      end
    end
  end

endmodule

### hw/rtl/tcce_queue.sv
// short fifo of segment plans between front and back end
`timescale 1ns / 1ps
module tcce_queue #(
  parameter int DEPTH = tcce_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  tcce_pkg::plan_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output tcce_pkg::plan_t rd_data
);
  import tcce_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  plan_t           mem [DEPTH];
  logic [AW-1:0]   wp, rp;
  logic [AW:0]     cnt;

  assign wr_ready = cnt != (AW+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= inc(wp);
      if (rd_valid && rd_ready) rp <= inc(rp);
      cnt <= cnt + (AW+1)'(wr_valid && wr_ready) - (AW+1)'(rd_valid && rd_ready);
    end
  end

endmodule

### hw/rtl/tcce_back.sv
// back end: expands segment plans into one command per cycle while the output is not stalled
`timescale 1ns / 1ps
module tcce_back #(
  parameter int CELL_HEIGHT = tcce_pkg::CELL_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               plan_valid,
  output logic               plan_ready,
  input  tcce_pkg::plan_t    plan,
  output logic               out_valid,
  input  logic               out_ready,
  output tcce_pkg::out_item_t out_item
);
  import tcce_pkg::*;

  logic [2:0]  seg_idx;
  logic [3:0]  prow;
  seg_t        s;
  logic        seg_end;
  logic        plan_end;
  logic        adv;
  out_item_t   o;
  logic [34:0] g;
  logic [2:0]  gr;

  assign s = plan.segs[seg_idx];
  assign seg_end = (s.op == OP_SCROLL || s.op == OP_CLEAR) ||
                   (prow == 4'(CELL_HEIGHT - 1));
  assign plan_end = seg_end && (seg_idx == plan.count - 3'd1);
  assign adv = plan_valid && (!out_valid || out_ready);
  assign plan_ready = adv && plan_end;
  assign g = font_glyph(s.glyph);
  assign gr = 3'(prow - 4'd2);

  always_comb begin
    o = '0;
    case (s.op)
      OP_SCROLL: o.kind = KIND_SCROLL;
      OP_CLEAR: o.kind = KIND_CLEAR;
      default: begin
        o.kind = KIND_ROW;
        o.cell_col = s.col;
        o.cell_row = s.row;
        o.pixel_row = prow;
        if (s.op == OP_PAINT) begin
          o.pixel_mask = 8'hFF;
          o.mask_color = 1'b1;
        end else if (s.op == OP_GLYPH && prow >= 4'd2 && prow < 4'd9) begin
          o.pixel_mask = {1'b0, g[34 - 5*gr -: 5], 2'b00};
        end
      end
    endcase
    o.last = plan_end && s.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seg_idx <= '0;
      prow <= '0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (adv) begin
        out_valid <= 1'b1;
        out_item <= o;
        if (seg_end) begin
          prow <= '0;
          seg_idx <= plan_end ? 3'd0 : seg_idx + 3'd1;
        end else begin
          prow <= prow + 4'd1;
        end
      end
    end
  end

endmodule

### hw/rtl/text_console_cell_engine_core.sv
// text console cell engine: cursor, wrap and scroll command generator
// an item is taken while in_ready is high; its plan is registered in the front end
// and written into the queue before the back end sees it; the back end emits one
// command per cycle while the output is not stalled, up to 37 per item (12 per cell row write run)
// the first command of an item then passes the back-end output register
// synchronous reset: cursor home, hidden, blink time zero, registers to defaults
`timescale 1ns / 1ps
module text_console_cell_engine_core #(
  parameter int CELL_HEIGHT = tcce_pkg::CELL_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcce_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tcce_pkg::out_item_t out_item
);
  import tcce_pkg::*;

  logic  f_valid, f_ready, q_valid, q_ready;
  plan_t f_plan, q_plan;

  tcce_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_item,
    .plan_valid(f_valid), .plan_ready(f_ready), .plan(f_plan)
  );

  tcce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_plan),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_plan)
  );

  tcce_back #(.CELL_HEIGHT(CELL_HEIGHT)) u_back (
    .clk, .rst,
    .plan_valid(q_valid), .plan_ready(q_ready), .plan(q_plan),
    .out_valid, .out_ready, .out_item
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output changed while stalled");
  a_plan_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> q_plan.count != 3'd0)
    else $error("empty plan in queue");
  a_row_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_ROW |-> out_item.pixel_mask == 8'd0)
    else $error("mask on non-row command");

endmodule
